// ----- hw/rtl/llma_pkg.sv -----
// Shared widths and constants for the least loaded machine assign block.
package llma_pkg;

    localparam int LEN_W     = 16;
    localparam int TIME_W    = 32;
    localparam int OUT_ID_W  = 4;
    localparam int CFG_W     = 4;
    localparam int CNT_RESET = 3;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

endpackage

// ----- hw/rtl/llma_job_if.sv -----
// Job channel: one job length per word.
interface llma_job_if import llma_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] job_length;

    modport source (output valid, output job_length, input ready);
    modport sink (input valid, input job_length, output ready);
endinterface

// ----- hw/rtl/llma_result_if.sv -----
// Result channel: machine id, start and end time per word.
interface llma_result_if import llma_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OUT_ID_W-1:0] machine_id;
    logic [TIME_W-1:0]   start_time;
    logic [TIME_W-1:0]   end_time;

    modport source (output valid, output machine_id, output start_time, output end_time,
                    input ready);
    modport sink (input valid, input machine_id, input start_time, input end_time,
                  output ready);
endinterface

// ----- hw/rtl/least_loaded_machine_assign.sv -----
// Greedy job scheduler over a min-heap of machine free times held in one memory.
//
//  channel   dir   handshake      payload
//  job       in    valid/ready    job_length[15:0]
//  result    out   valid/ready    machine_id[3:0], start_time[31:0], end_time[31:0]
//  cfg       in    cfg_we         cfg_wdata[3:0] (machine_count)
//
// One job at a time through a read-modify-write sequencer on the heap memory (registered
// read ports): take the root, sift the last entry down (with a separate place step when it
// sinks past the last level), sift the freed machine up (with a separate insert step when it
// rises to the root), then emit the result. The result register lets the next job enter
// while a word waits on result. Reset and any cfg write clear the per-entry valid bits, so
// the heap reads as ids 1..count at time 0 with no clearing pass.
module least_loaded_machine_assign import llma_pkg::*; #(
    parameter int MAX_MACHINES = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata,
    llma_job_if.sink              job,
    llma_result_if.source         result
);

    localparam int AW    = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int ID_W  = $clog2(MAX_MACHINES + 1);
    localparam int CW    = $clog2(MAX_MACHINES + 1);
    localparam int PW    = $clog2(2 * MAX_MACHINES + 2);
    localparam int XW    = (CW > CFG_W) ? CW : CFG_W;
    localparam int ENT_W = ID_W + TIME_W;
    localparam int RST_COUNT = (CNT_RESET > MAX_MACHINES) ? MAX_MACHINES : CNT_RESET;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TAKE  = 3'd1;
    localparam logic [2:0] S_DOWN  = 3'd2;
    localparam logic [2:0] S_PLACE = 3'd3;
    localparam logic [2:0] S_PUT   = 3'd4;
    localparam logic [2:0] S_UP    = 3'd5;
    localparam logic [2:0] S_INS   = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0]             state_reg, state_next;
    logic [CW-1:0]          count_reg;
    logic [MAX_MACHINES-1:0] valid_reg;

    logic [LEN_W-1:0]       len_reg, len_next;
    logic [PW-1:0]          size_reg, size_next;
    logic [PW-1:0]          pos_reg, pos_next;
    logic [PW-1:0]          kid_reg, kid_next;     // child in sift down, parent in sift up
    logic [ID_W-1:0]        moved_id_reg, moved_id_next;
    logic [TIME_W-1:0]      moved_time_reg, moved_time_next;
    logic [ID_W-1:0]        top_id_reg, top_id_next;
    logic [TIME_W-1:0]      start_reg, start_next;
    logic [TIME_W-1:0]      free_reg, free_next;
    logic [TIME_W-1:0]      end_reg, end_next;

    logic                   out_valid_reg, out_valid_next;
    logic [OUT_ID_W-1:0]    out_id_reg, out_id_next;
    logic [TIME_W-1:0]      out_start_reg, out_start_next;
    logic [TIME_W-1:0]      out_end_reg, out_end_next;

    // heap memory, entry = {id, free time}
    logic [ENT_W-1:0]       mem [0:MAX_MACHINES-1];
    logic [ENT_W-1:0]       rd_a_reg, rd_b_reg;
    logic                   va_reg, vb_reg;
    logic [AW-1:0]          aa_reg, ab_reg;

    logic                   rd_en, wr_en;
    logic [AW-1:0]          rd_addr_a, rd_addr_b, wr_addr;
    logic [ENT_W-1:0]       wr_data;

    logic [ID_W-1:0]        a_id, b_id, c_id;
    logic [TIME_W-1:0]      a_time, b_time, c_time;
    logic [PW-1:0]          ck, step;
    logic                   take_right;
    logic [TIME_W:0]        sum_full, end_full;
    logic [XW-1:0]          cfg_ext;
    logic [CW-1:0]          cfg_count;

    // entries never written since the last fill read as their fill value
    assign a_id   = va_reg ? rd_a_reg[ENT_W-1:TIME_W] : ID_W'(aa_reg) + ID_W'(1);
    assign a_time = va_reg ? rd_a_reg[TIME_W-1:0] : '0;
    assign b_id   = vb_reg ? rd_b_reg[ENT_W-1:TIME_W] : ID_W'(ab_reg) + ID_W'(1);
    assign b_time = vb_reg ? rd_b_reg[TIME_W-1:0] : '0;

    assign take_right = (kid_reg < size_reg) && (a_time > b_time);
    assign c_id       = take_right ? b_id : a_id;
    assign c_time     = take_right ? b_time : a_time;
    assign ck         = take_right ? kid_reg + PW'(1) : kid_reg;

    assign sum_full = {1'b0, a_time} + (TIME_W+1)'(len_reg);
    assign end_full = sum_full - (TIME_W+1)'(1);

    assign cfg_ext   = XW'(cfg_wdata);
    assign cfg_count = (cfg_ext == '0) ? CW'(1) :
                       (cfg_ext > XW'(MAX_MACHINES)) ? CW'(MAX_MACHINES) : CW'(cfg_ext);

    assign job.ready         = (state_reg == S_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.machine_id = out_id_reg;
    assign result.start_time = out_start_reg;
    assign result.end_time   = out_end_reg;

    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        size_next       = size_reg;
        pos_next        = pos_reg;
        kid_next        = kid_reg;
        moved_id_next   = moved_id_reg;
        moved_time_next = moved_time_reg;
        top_id_next     = top_id_reg;
        start_next      = start_reg;
        free_next       = free_reg;
        end_next        = end_reg;
        out_valid_next  = out_valid_reg & ~result.ready;
        out_id_next     = out_id_reg;
        out_start_next  = out_start_reg;
        out_end_next    = out_end_reg;
        rd_en           = 1'b0;
        rd_addr_a       = '0;
        rd_addr_b       = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        step            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (job.valid)
                begin
                    len_next   = job.job_length;
                    rd_en      = 1'b1;
                    rd_addr_a  = '0;
                    rd_addr_b  = AW'(count_reg - CW'(1));
                    state_next = S_TAKE;
                end
            end
            S_TAKE:
            begin
                top_id_next     = a_id;
                start_next      = a_time;
                free_next       = sum_full[TIME_W] ? TIME_MAX : sum_full[TIME_W-1:0];
                if (len_reg == '0)
                    end_next = a_time;
                else
                    end_next = end_full[TIME_W] ? TIME_MAX : end_full[TIME_W-1:0];
                moved_id_next   = b_id;
                moved_time_next = b_time;
                size_next       = PW'(count_reg) - PW'(1);
                pos_next        = PW'(1);
                kid_next        = PW'(2);
                if (PW'(2) <= PW'(count_reg) - PW'(1))
                begin
                    rd_en      = 1'b1;
                    rd_addr_a  = AW'(1);
                    rd_addr_b  = AW'(2);
                    state_next = S_DOWN;
                end
                else
                begin
                    // one or two machines: the last entry goes straight to the root
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_data    = {b_id, b_time};
                    state_next = S_PUT;
                end
            end
            S_DOWN:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(pos_reg - PW'(1));
                if (moved_time_reg <= c_time)
                begin
                    wr_data    = {moved_id_reg, moved_time_reg};
                    state_next = S_PUT;
                end
                else
                begin
                    wr_data  = {c_id, c_time};
                    pos_next = ck;
                    step     = PW'({ck, 1'b0});
                    kid_next = step;
                    if (step <= size_reg)
                    begin
                        rd_en     = 1'b1;
                        rd_addr_a = AW'(step - PW'(1));
                        rd_addr_b = AW'(step);
                    end
                    else
                        state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = AW'(pos_reg - PW'(1));
                wr_data    = {moved_id_reg, moved_time_reg};
                state_next = S_PUT;
            end
            S_PUT:
            begin
                pos_next = PW'(count_reg);
                step     = PW'(count_reg) >> 1;
                kid_next = step;
                if (step != '0)
                begin
                    rd_en      = 1'b1;
                    rd_addr_a  = AW'(step - PW'(1));
                    state_next = S_UP;
                end
                else
                    state_next = S_INS;
            end
            S_UP:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(pos_reg - PW'(1));
                if (a_time > free_reg)
                begin
                    wr_data  = {a_id, a_time};
                    pos_next = kid_reg;
                    step     = kid_reg >> 1;
                    kid_next = step;
                    if (step != '0)
                    begin
                        rd_en     = 1'b1;
                        rd_addr_a = AW'(step - PW'(1));
                    end
                    else
                        state_next = S_INS;
                end
                else
                begin
                    wr_data    = {top_id_reg, free_reg};
                    state_next = S_EMIT;
                end
            end
            S_INS:
            begin
                wr_en      = 1'b1;
                wr_addr    = AW'(pos_reg - PW'(1));
                wr_data    = {top_id_reg, free_reg};
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = OUT_ID_W'(top_id_reg);
                    out_start_next = start_reg;
                    out_end_next   = end_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CW'(RST_COUNT);
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                count_reg <= cfg_count;
                valid_reg <= '0;
            end
            else if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg        <= len_next;
        size_reg       <= size_next;
        pos_reg        <= pos_next;
        kid_reg        <= kid_next;
        moved_id_reg   <= moved_id_next;
        moved_time_reg <= moved_time_next;
        top_id_reg     <= top_id_next;
        start_reg      <= start_next;
        free_reg       <= free_next;
        end_reg        <= end_next;
        out_id_reg     <= out_id_next;
        out_start_reg  <= out_start_next;
        out_end_reg    <= out_end_next;
    end

    // heap memory: two registered read ports, one write port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
            va_reg   <= valid_reg[rd_addr_a];
            vb_reg   <= valid_reg[rd_addr_b];
            aa_reg   <= rd_addr_a;
            ab_reg   <= rd_addr_b;
        end
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

endmodule

// ----- verif/tb_least_loaded_machine_assign.sv -----
`timescale 1ns / 100ps
// Testbench for least_loaded_machine_assign: heap scheduler predicted in-bench, results checked in order.
module tb_least_loaded_machine_assign;
    import llma_pkg::*;

    localparam int MACHINES      = 8;
    localparam int SEGMENT_JOBS  = 325;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 4_000_000;

    typedef struct packed {
        logic [OUT_ID_W-1:0] id;
        logic [TIME_W-1:0]   free_at;
    } machine_t;

    typedef struct packed {
        logic [OUT_ID_W-1:0] machine_id;
        logic [TIME_W-1:0]   start_time;
        logic [TIME_W-1:0]   end_time;
    } assignment_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    llma_job_if    job_ch ();
    llma_result_if res_ch ();

    least_loaded_machine_assign #(
        .MAX_MACHINES(MACHINES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .job       (job_ch),
        .result    (res_ch)
    );

    machine_t    free_heap [1:MACHINES];
    int unsigned live_machines;
    assignment_t assignments_q[$];
    int          fail_count  = 0;
    int          cycle_count = 0;
    int          send_pct    = 35;
    int          recv_pct    = 71;

    always #5 clk = ~clk;

    // Heap starts as ids 1..count, all free at time zero.
    function automatic void heap_refill(input logic [CFG_W-1:0] value);
        int k;
        if (value == 0)
            live_machines = 1;
        else if (value > MACHINES)
            live_machines = MACHINES;
        else
            live_machines = value;
        for (k = 1; k <= MACHINES; k++)
        begin
            free_heap[k].id      = (k <= live_machines) ? OUT_ID_W'(k) : '0;
            free_heap[k].free_at = '0;
        end
    endfunction

    function automatic assignment_t schedule_job(input logic [LEN_W-1:0] len);
        machine_t    top;
        machine_t    moved;
        int unsigned size;
        int unsigned pos;
        int unsigned kid;
        int unsigned up;
        bit          done;
        logic [TIME_W:0] sum;
        logic [TIME_W:0] last_tick;
        assignment_t a;
        top   = free_heap[1];
        moved = free_heap[live_machines];
        size  = live_machines - 1;
        pos   = 1;
        kid   = 2;
        done  = 1'b0;
        // sift down: right child only when left is strictly later
        while (!done && kid <= size)
        begin
            if (kid < size && free_heap[kid].free_at > free_heap[kid + 1].free_at)
                kid++;
            if (moved.free_at <= free_heap[kid].free_at)
                done = 1'b1;
            else
            begin
                free_heap[pos] = free_heap[kid];
                pos = kid;
                kid = kid * 2;
            end
        end
        free_heap[pos] = moved;

        sum       = {1'b0, top.free_at} + len;
        last_tick = (len == 0) ? sum : sum - 1;
        if (last_tick[TIME_W])
            last_tick = {1'b0, TIME_MAX};
        if (sum[TIME_W])
            sum = {1'b0, TIME_MAX};
        a.machine_id = top.id;
        a.start_time = top.free_at;
        a.end_time   = last_tick[TIME_W-1:0];

        // sift up while the parent is strictly later
        top.free_at = sum[TIME_W-1:0];
        pos = live_machines;
        up  = pos / 2;
        while (up >= 1 && free_heap[up].free_at > top.free_at)
        begin
            free_heap[pos] = free_heap[up];
            pos = up;
            up  = up / 2;
        end
        free_heap[pos] = top;
        return a;
    endfunction

    // Returns at the rising edge that took the word; valid stays up until the next call.
    task automatic send_job(input logic [LEN_W-1:0] len);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_pct)
        begin
            job_ch.valid <= 1'b0;
            @(negedge clk);
        end
        job_ch.valid      <= 1'b1;
        job_ch.job_length <= len;
        @(posedge clk);
        while (!job_ch.ready)
            @(posedge clk);
        assignments_q.push_back(schedule_job(len));
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        job_ch.valid <= 1'b0;
        while (assignments_q.size() != 0)
            @(posedge clk);
        // heap write-back ends before the last result word is emitted; settle anyway
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_machine_count(input logic [CFG_W-1:0] value);
        wait_for_drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        heap_refill(value);
    endtask

    function automatic logic [LEN_W-1:0] random_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        else if (r < 16)
            return '1;
        else if (r < 45)
            return LEN_W'($urandom_range(1, 4));    // small lengths give lots of ties
        else if (r < 60)
            return LEN_W'($urandom_range(1, 255));
        else
            return LEN_W'($urandom());
    endfunction

    task automatic test_reset_heap();
        logic [LEN_W-1:0] lens [14];
        int i;
        lens = '{16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h5555,
                 16'hAAAA, 16'h8000, 16'h7FFF, 16'h0002, 16'h0002, 16'h0002, 16'h0000};
        for (i = 0; i < 14; i++)
            send_job(lens[i]);
    endtask

    task automatic test_count_extremes();
        int i;
        write_machine_count(4'd0);          // taken as one machine
        send_job(16'h0001);
        send_job(16'h0000);
        send_job(16'hFFFF);
        write_machine_count(4'd15);         // clamps to the full heap
        for (i = 0; i < MACHINES; i++)
            send_job(16'h0003);
    endtask

    task automatic test_random_traffic(input logic [CFG_W-1:0] count, input int s_pct,
                                       input int r_pct);
        int i;
        write_machine_count(count);
        send_pct = s_pct;
        recv_pct = r_pct;
        for (i = 0; i < SEGMENT_JOBS; i++)
            send_job(random_length());
    endtask

    always @(negedge clk)
        res_ch.ready <= ($urandom_range(0, 99) >= recv_pct);

    always @(posedge clk)
    begin : result_check
        assignment_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (assignments_q.size() == 0)
            begin
                $display("%0t: unexpected result word id %0d start %0d end %0d", $time,
                         res_ch.machine_id, res_ch.start_time, res_ch.end_time);
                fail_count++;
            end
            else
            begin
                want = assignments_q.pop_front();
                if (res_ch.machine_id !== want.machine_id)
                begin
                    $display("%0t: machine_id expected %0d actual %0d", $time,
                             want.machine_id, res_ch.machine_id);
                    fail_count++;
                end
                if (res_ch.start_time !== want.start_time)
                begin
                    $display("%0t: start_time expected %0d actual %0d", $time,
                             want.start_time, res_ch.start_time);
                    fail_count++;
                end
                if (res_ch.end_time !== want.end_time)
                begin
                    $display("%0t: end_time expected %0d actual %0d", $time,
                             want.end_time, res_ch.end_time);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("least_loaded_machine_assign verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        job_ch.valid      = 1'b0;
        job_ch.job_length = '0;
        res_ch.ready      = 1'b0;
        heap_refill(CFG_W'(CNT_RESET));
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_heap();
        test_count_extremes();
        test_random_traffic(4'd8, 35, 71);
        test_random_traffic(4'd5, 35, 71);
        test_random_traffic(4'd15, 71, 35);
        test_random_traffic(4'd10, 71, 35);
        test_random_traffic(4'd1, 0, 0);
        test_random_traffic(CFG_W'($urandom_range(0, 15)), 0, 0);

        wait_for_drain();
        if (fail_count == 0)
            $display("least_loaded_machine_assign verification clean");
        else
            $display("least_loaded_machine_assign verification failed");
        $finish;
    end

endmodule
